// ===== hw/rtl/segment_rect_overlap_test_core_macros.svh =====
// assertion macros for the segment/rectangle overlap test core
`ifndef SEGMENT_RECT_OVERLAP_TEST_CORE_MACROS_SVH
`define SEGMENT_RECT_OVERLAP_TEST_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SRO_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sro assertion failed");
`define SRO_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sro reset check failed");
`else
`define SRO_ASSERT(label, prop)
`define SRO_ASSERT_RST(label, prop)
`endif
`endif

// ===== hw/rtl/sro_pkg.sv =====
// shared types, region codes and the region-pair action table
`timescale 1ns / 1ps
`default_nettype none
package sro_pkg;

  localparam int OUT_TDATA_W = 8;

  localparam logic [3:0] REG_C = 4'd4;

  localparam logic [3:0] ACT_FALSE       = 4'd0;
  localparam logic [3:0] ACT_TRUE        = 4'd1;
  localparam logic [3:0] ACT_CORNER_BASE = 4'd2;

  localparam logic [1:0] COL_LEFT  = 2'd0;
  localparam logic [1:0] COL_MID   = 2'd1;
  localparam logic [1:0] COL_RIGHT = 2'd2;

  localparam logic [1:0] ROW_TOP    = 2'd0;
  localparam logic [1:0] ROW_MID    = 2'd1;
  localparam logic [1:0] ROW_BOTTOM = 2'd2;

  typedef struct packed {
    logic need_cross;
    logic hit;
  } sro_ctl_t;

  // rows: first endpoint region, columns: second endpoint region
  localparam logic [3:0] PAIR_ACTION [0:80] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd7, 4'd0, 4'd4, 4'd1,
    4'd0, 4'd0, 4'd0, 4'd2, 4'd0, 4'd7, 4'd2, 4'd1, 4'd7,
    4'd0, 4'd0, 4'd0, 4'd2, 4'd0, 4'd0, 4'd1, 4'd9, 4'd0,
    4'd0, 4'd3, 4'd3, 4'd0, 4'd0, 4'd1, 4'd0, 4'd4, 4'd4,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd6, 4'd6, 4'd0, 4'd1, 4'd0, 4'd0, 4'd9, 4'd9, 4'd0,
    4'd0, 4'd3, 4'd1, 4'd0, 4'd0, 4'd8, 4'd0, 4'd0, 4'd0,
    4'd5, 4'd1, 4'd8, 4'd5, 4'd0, 4'd8, 4'd0, 4'd0, 4'd0,
    4'd1, 4'd6, 4'd0, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  function automatic logic [3:0] pair_action(input logic [3:0] r1, input logic [3:0] r2);
    logic [6:0] idx;
    idx = {3'b000, r1} * 7'd9 + {3'b000, r2};
    return PAIR_ACTION[idx];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sro_classify.sv =====
// first stage: endpoint regions, table decode and operand differences
`timescale 1ns / 1ps
`default_nettype none
module sro_classify #(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire [8*COORD_BITS-1:0]       coords,
  output logic signed [COORD_BITS:0]   dx,
  output logic signed [COORD_BITS:0]   dy,
  output logic signed [COORD_BITS:0]   ex,
  output logic signed [COORD_BITS:0]   ey,
  output sro_pkg::sro_ctl_t            ctl
);
  import sro_pkg::*;

  localparam int W = COORD_BITS;

  logic signed [W-1:0] x1, y1, x2, y2, l, t, r, b;
  logic signed [W-1:0] ax, ay, bx, by, cx, cy;
  logic [3:0]          r1, r2, act, code;
  logic signed [W:0]   dx_next, dy_next, ex_next, ey_next;
  sro_ctl_t            ctl_next;

  function automatic logic [3:0] region(
    input logic signed [W-1:0] px, input logic signed [W-1:0] py,
    input logic signed [W-1:0] el, input logic signed [W-1:0] et,
    input logic signed [W-1:0] er, input logic signed [W-1:0] eb);
    logic [1:0] col;
    logic [1:0] row;
    if (px < el) begin
      col = COL_LEFT;
    end else if (px > er) begin
      col = COL_RIGHT;
    end else begin
      col = COL_MID;
    end
    if (py < et) begin
      row = ROW_TOP;
    end else if (py > eb) begin
      row = ROW_BOTTOM;
    end else begin
      row = ROW_MID;
    end
    return {2'b00, col} * 4'd3 + {2'b00, row};
  endfunction

  assign x1 = coords[0*W +: W];
  assign y1 = coords[1*W +: W];
  assign x2 = coords[2*W +: W];
  assign y2 = coords[3*W +: W];
  assign l  = coords[4*W +: W];
  assign t  = coords[5*W +: W];
  assign r  = coords[6*W +: W];
  assign b  = coords[7*W +: W];

  always_comb begin
    r1   = region(x1, y1, l, t, r, b);
    r2   = region(x2, y2, l, t, r, b);
    act  = pair_action(r1, r2);
    code = act - ACT_CORNER_BASE;
    cx   = code[1] ? r : l;
    cy   = code[2] ? b : t;
    if (code[0]) begin
      ax = x2;
      ay = y2;
      bx = x1;
      by = y1;
    end else begin
      ax = x1;
      ay = y1;
      bx = x2;
      by = y2;
    end
    dx_next = (W+1)'(bx) - (W+1)'(ax);
    dy_next = (W+1)'(by) - (W+1)'(ay);
    ex_next = (W+1)'(cx) - (W+1)'(ax);
    ey_next = (W+1)'(cy) - (W+1)'(ay);
    if (r1 == REG_C || r2 == REG_C) begin
      ctl_next.need_cross = 1'b0;
      ctl_next.hit        = 1'b1;
    end else if (act < ACT_CORNER_BASE) begin
      ctl_next.need_cross = 1'b0;
      ctl_next.hit        = (act == ACT_TRUE);
    end else begin
      ctl_next.need_cross = 1'b1;
      ctl_next.hit        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= dx_next;
      dy  <= dy_next;
      ex  <= ex_next;
      ey  <= ey_next;
      ctl <= ctl_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sro_cross.sv =====
// second and third stages: cross product terms, then sign and final answer
`timescale 1ns / 1ps
`default_nettype none
module sro_cross #(
  parameter int COORD_BITS = 16
) (
  input  wire                        clk,
  input  wire                        en2,
  input  wire                        en3,
  input  wire signed [COORD_BITS:0]  dx,
  input  wire signed [COORD_BITS:0]  dy,
  input  wire signed [COORD_BITS:0]  ex,
  input  wire signed [COORD_BITS:0]  ey,
  input  sro_pkg::sro_ctl_t          ctl,
  output logic                       overlaps
);
  import sro_pkg::*;

  localparam int PW = 2*COORD_BITS + 2;

  logic signed [PW-1:0] p1, p2;
  logic signed [PW:0]   diff;
  sro_ctl_t             ctl2;
  logic                 overlaps_next;

  always_ff @(posedge clk) begin
    if (en2) begin
      p1   <= PW'(dy) * PW'(ex);
      p2   <= PW'(dx) * PW'(ey);
      ctl2 <= ctl;
    end
  end

  always_comb begin
    diff          = (PW+1)'(p1) - (PW+1)'(p2);
    overlaps_next = ctl2.need_cross ? !diff[PW] : ctl2.hit;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      overlaps <= overlaps_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/segment_rect_overlap_test_core.sv =====
// segment/rectangle overlap test, top level with stream handshake
// an accepted input beat passes the classify, cross product and result registers to its result beat
// throughput: one beat per cycle unless the output stalls, set by the three-stage pipeline
// (regions and differences, two multipliers, subtract and sign)
// stalls back up stage by stage; bubbles in the pipe are filled while stalled
// rst clears the stage valid bits only; no state is kept between beats
`timescale 1ns / 1ps
`default_nettype none
`include "segment_rect_overlap_test_core_macros.svh"
module segment_rect_overlap_test_core #(
  parameter int COORD_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  // start_x, start_y, end_x, end_y, rect_left, rect_top, rect_right, rect_bottom
  input  wire [8*COORD_BITS-1:0]             s_tdata,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // overlaps, then zero padding
  output logic [sro_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import sro_pkg::*;

  logic                      v1, v2;
  logic                      en1, en2, en3;
  logic signed [COORD_BITS:0] dx, dy, ex, ey;
  sro_ctl_t                  ctl;
  logic                      overlaps;

  assign en3      = !m_tvalid || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= s_tvalid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        m_tvalid <= v2;
      end
    end
  end

  sro_classify #(
    .COORD_BITS(COORD_BITS)
  ) u_classify (
    .clk    (clk),
    .en     (en1),
    .coords (s_tdata),
    .dx     (dx),
    .dy     (dy),
    .ex     (ex),
    .ey     (ey),
    .ctl    (ctl)
  );

  sro_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk      (clk),
    .en2      (en2),
    .en3      (en3),
    .dx       (dx),
    .dy       (dy),
    .ex       (ex),
    .ey       (ey),
    .ctl      (ctl),
    .overlaps (overlaps)
  );

  assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, overlaps};

  `SRO_ASSERT_RST(a_reset_empties, rst |=> !m_tvalid)
  `SRO_ASSERT(a_ready_on_bubble, (!v1 || !v2 || !m_tvalid) |-> s_tready)
  `SRO_ASSERT(a_accept_enters, (s_tvalid && s_tready) |=> v1)
  `SRO_ASSERT(a_stall_keeps_pipe, (v2 && m_tvalid && !m_tready) |=> (v2 && m_tvalid))

endmodule
`default_nettype wire

// ===== bench/segment_rect_overlap_test_core_tb.sv =====
// self-checking stream testbench for the segment/rectangle overlap test core
`timescale 1ns / 1ps
module segment_rect_overlap_test_core_tb;

  localparam int CW = 16;
  localparam int CMIN = -32768;
  localparam int CMAX = 32767;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 215;

  // region index is column * 3 + row
  typedef enum int {
    RG_TL, RG_L, RG_BL, RG_T, RG_C, RG_B, RG_TR, RG_R, RG_BR
  } region_e;

  // corner tests: FWD takes start then end, REV takes end then start
  typedef enum logic [3:0] {
    PA_NO, PA_YES,
    PA_TL_FWD, PA_TL_REV, PA_TR_FWD, PA_TR_REV,
    PA_BL_FWD, PA_BL_REV, PA_BR_FWD, PA_BR_REV
  } pair_act_e;

  localparam pair_act_e PAIR_RULE [9][9] = '{
    '{PA_NO, PA_NO, PA_NO, PA_NO, PA_NO, PA_BL_REV, PA_NO, PA_TR_FWD, PA_YES},
    '{PA_NO, PA_NO, PA_NO, PA_TL_FWD, PA_NO, PA_BL_REV, PA_TL_FWD, PA_YES, PA_BL_REV},
    '{PA_NO, PA_NO, PA_NO, PA_TL_FWD, PA_NO, PA_NO, PA_YES, PA_BR_REV, PA_NO},
    '{PA_NO, PA_TL_REV, PA_TL_REV, PA_NO, PA_NO, PA_YES, PA_NO, PA_TR_FWD, PA_TR_FWD},
    '{PA_NO, PA_NO, PA_NO, PA_NO, PA_NO, PA_NO, PA_NO, PA_NO, PA_NO},
    '{PA_BL_FWD, PA_BL_FWD, PA_NO, PA_YES, PA_NO, PA_NO, PA_BR_REV, PA_BR_REV, PA_NO},
    '{PA_NO, PA_TL_REV, PA_YES, PA_NO, PA_NO, PA_BR_FWD, PA_NO, PA_NO, PA_NO},
    '{PA_TR_REV, PA_YES, PA_BR_FWD, PA_TR_REV, PA_NO, PA_BR_FWD, PA_NO, PA_NO, PA_NO},
    '{PA_YES, PA_BL_FWD, PA_NO, PA_TR_REV, PA_NO, PA_NO, PA_NO, PA_NO, PA_NO}
  };

  // last field in the lowest bits
  typedef struct packed {
    logic signed [CW-1:0] rect_bottom;
    logic signed [CW-1:0] rect_right;
    logic signed [CW-1:0] rect_top;
    logic signed [CW-1:0] rect_left;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_x;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  query_t s_query = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [sro_pkg::OUT_TDATA_W-1:0] m_tdata;

  query_t query_backlog[$];
  bit expected_hits[$];
  bit expected_hit;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  segment_rect_overlap_test_core #(
    .COORD_BITS(CW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_query),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic region_e region_of(longint x, longint y, longint lo_x, longint lo_y,
                                        longint hi_x, longint hi_y);
    int col;
    int row;
    col = (x < lo_x) ? 0 : (x > hi_x) ? 2 : 1;
    row = (y < lo_y) ? 0 : (y > hi_y) ? 2 : 1;
    return region_e'(col * 3 + row);
  endfunction

  function automatic bit predict_overlap(query_t q);
    longint x1, y1, x2, y2, l, t, r, b;
    longint ax, ay, bx, by, cx, cy, side;
    region_e r1, r2;
    pair_act_e act;
    x1 = q.start_x;
    y1 = q.start_y;
    x2 = q.end_x;
    y2 = q.end_y;
    l = q.rect_left;
    t = q.rect_top;
    r = q.rect_right;
    b = q.rect_bottom;
    r1 = region_of(x1, y1, l, t, r, b);
    r2 = region_of(x2, y2, l, t, r, b);
    if (r1 == RG_C || r2 == RG_C) return 1'b1;
    act = PAIR_RULE[r1][r2];
    if (act == PA_NO) return 1'b0;
    if (act == PA_YES) return 1'b1;
    cx = (act == PA_TR_FWD || act == PA_TR_REV || act == PA_BR_FWD || act == PA_BR_REV)
         ? r : l;
    cy = (act == PA_BL_FWD || act == PA_BL_REV || act == PA_BR_FWD || act == PA_BR_REV)
         ? b : t;
    if (act == PA_TL_REV || act == PA_TR_REV || act == PA_BL_REV || act == PA_BR_REV) begin
      ax = x2; ay = y2; bx = x1; by = y1;
    end else begin
      ax = x1; ay = y1; bx = x2; by = y2;
    end
    side = (by - ay) * (cx - ax) - (bx - ax) * (cy - ay);
    return side >= 0;
  endfunction

  function automatic int rand_coord();
    return int'(shortint'($urandom));
  endfunction

  function automatic int rand_extent();
    case ($urandom_range(3))
      0: return int'($urandom_range(3));
      1: return int'($urandom_range(100));
      2: return int'($urandom_range(5000));
      default: return int'($urandom_range(65535));
    endcase
  endfunction

  // band 0 below lo, 1 between lo and hi, 2 above hi
  function automatic int pick_coord(int band, int lo, int hi);
    int span;
    int reach;
    if (band == 0) begin
      if (lo <= CMIN) return rand_coord();
      span = lo - CMIN;
      reach = ($urandom_range(1) == 1 && span > 100) ? 100 : span;
      return lo - int'($urandom_range(reach, 1));
    end
    if (band == 2) begin
      if (hi >= CMAX) return rand_coord();
      span = CMAX - hi;
      reach = ($urandom_range(1) == 1 && span > 100) ? 100 : span;
      return hi + int'($urandom_range(reach, 1));
    end
    if (lo > hi) return rand_coord();
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(hi - lo));
    endcase
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(2))
      0: return CMIN;
      1: return CMAX;
      default: return rand_coord();
    endcase
  endfunction

  task automatic add_query(int sx, int sy, int ex, int ey, int l, int t, int r, int b);
    query_t q;
    q.start_x = CW'(sx);
    q.start_y = CW'(sy);
    q.end_x = CW'(ex);
    q.end_y = CW'(ey);
    q.rect_left = CW'(l);
    q.rect_top = CW'(t);
    q.rect_right = CW'(r);
    q.rect_bottom = CW'(b);
    query_backlog.push_back(q);
  endtask

  task automatic add_random_query();
    int l, t, r, b, sx, sy, ex, ey;
    int kind;
    int reg1, reg2;
    kind = int'($urandom_range(99));
    l = ($urandom_range(15) == 0) ? CMIN : rand_coord();
    t = ($urandom_range(15) == 0) ? CMIN : rand_coord();
    r = ($urandom_range(15) == 0) ? CMAX : l + rand_extent();
    b = ($urandom_range(15) == 0) ? CMAX : t + rand_extent();
    if (r > CMAX) r = CMAX;
    if (b > CMAX) b = CMAX;
    if (kind >= 80 && kind < 88) begin
      // inverted rectangle
      r = l - rand_extent() - 1;
      b = t - rand_extent() - 1;
      if (r < CMIN) r = CMIN;
      if (b < CMIN) b = CMIN;
    end
    reg1 = int'($urandom_range(8));
    reg2 = int'($urandom_range(8));
    sx = pick_coord(reg1 / 3, l, r);
    sy = pick_coord(reg1 % 3, t, b);
    ex = pick_coord(reg2 / 3, l, r);
    ey = pick_coord(reg2 % 3, t, b);
    if (kind >= 70 && kind < 80) begin
      sx = rand_coord(); sy = rand_coord(); ex = rand_coord(); ey = rand_coord();
      l = rand_coord(); t = rand_coord(); r = rand_coord(); b = rand_coord();
    end else if (kind >= 88 && kind < 94) begin
      ex = sx;
      ey = sy;
    end else if (kind >= 94) begin
      sx = pick_extreme(); sy = pick_extreme(); ex = pick_extreme(); ey = pick_extreme();
    end
    add_query(sx, sy, ex, ey, l, t, r, b);
  endtask

  task automatic note_failure(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endtask

  task automatic wait_drained();
    while (query_backlog.size() != 0 || s_tvalid || expected_hits.size() != 0)
      @(posedge clk);
  endtask

  // driver: a beat leaves the backlog when the slot is free
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_hits.push_back(predict_overlap(s_query));
      if (!s_tvalid || s_tready) begin
        if (query_backlog.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          s_query <= query_backlog.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_hits.size() == 0) begin
        note_failure($sformatf("unexpected result beat: tdata %h", m_tdata));
      end else begin
        expected_hit = expected_hits.pop_front();
        if (m_tdata !== {{(sro_pkg::OUT_TDATA_W - 1){1'b0}}, expected_hit})
          note_failure($sformatf("overlaps mismatch: expected %0d, got tdata %h",
                                 expected_hit, m_tdata));
      end
    end
    m_tready <= rst ? 1'b0 : (int'($urandom_range(99)) >= recv_stall_pct);
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("segment_rect_overlap_test_core_tb: FAIL");
    $finish;
  end

  initial begin
    int phase;
    int i;
    int send_idle [4];
    int recv_stall [4];
    send_idle = '{0, 50, 0, 35};
    recv_stall = '{0, 0, 50, 35};

    // inside, on an edge, on a corner
    add_query(10, 10, 20, 20, 0, 0, 100, 100);
    add_query(0, 50, -500, -500, 0, 0, 100, 100);
    add_query(500, 500, 100, 100, 0, 0, 100, 100);
    // one outer band, straight through, corner cut hit, miss and exact touch
    add_query(-50, -10, -20, 200, 0, 0, 100, 100);
    add_query(-10, -10, 200, 200, 0, 0, 100, 100);
    add_query(-10, 50, 50, -10, 0, 0, 100, 100);
    add_query(-10, 5, 5, -10, 0, 0, 100, 100);
    add_query(-10, 10, 10, -10, 0, 0, 100, 100);
    add_query(50, -10, 50, 200, 0, 0, 100, 100);
    add_query(150, -5, 150, 300, 0, 0, 100, 100);
    add_query(200, 50, 50, 200, 0, 0, 100, 100);
    // full range rectangle and extreme coordinates
    add_query(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX);
    add_query(CMIN, CMIN, CMAX, 15, 0, 10, 10, 20);
    add_query(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX);
    add_query(CMIN, CMAX, CMAX, CMAX - 1, CMIN + 1, CMAX, CMIN + 1, CMAX);
    // inverted rectangle
    add_query(0, 0, 20, 20, 10, 10, -10, -10);
    add_query(0, 0, 0, 5, 10, 10, -10, -10);
    add_query(-20, 0, 20, 0, 10, -10, -10, 10);
    // degenerate segment outside and inside
    add_query(-5, 50, -5, 50, 0, 0, 100, 100);
    add_query(50, 50, 50, 50, 0, 0, 100, 100);
    // all bits set and sign bit patterns
    add_query(-1, -1, -1, -1, -1, -1, -1, -1);
    add_query(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX);
    add_query(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_idle[phase];
      recv_stall_pct = recv_stall[phase];
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        add_random_query();
        if (phase == 1 && i == RANDOM_PER_PHASE / 2) wait_drained();
      end
      while (query_backlog.size() != 0) @(posedge clk);
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("segment_rect_overlap_test_core_tb: PASS");
    end else begin
      $display("segment_rect_overlap_test_core_tb: FAIL");
    end
    $finish;
  end

endmodule
